### src/sdtq_pkg.sv
// shared types, codes and constants of the sorted deadline timer queue
package sdtq_pkg;

  localparam int NTIMERS_DEF = 16;

  localparam logic [31:0] SLACK_RESET = 32'd500000;
  localparam logic [30:0] NS_PER_SEC  = 31'd1000000000;
  localparam logic [30:0] NS_PER_USEC = 31'd1000;

  // input operations
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_FIRED   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  // classified commands from front to back
  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;
  localparam logic [1:0] CMD_REJECT = 2'd3;

  // list operations
  localparam logic [1:0] LIST_NOP    = 2'd0;
  localparam logic [1:0] LIST_INSERT = 2'd1;
  localparam logic [1:0] LIST_REMOVE = 2'd2;
  localparam logic [1:0] LIST_POP    = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  timer_id;
    logic [31:0] delay_usec;
    logic [63:0] now_ns;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  fired_id;
    logic        any_fired;
    logic [34:0] wait_sec;
    logic [19:0] wait_usec;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [3:0]  id;
    logic [63:0] deadline;
    logic [63:0] now;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  id;
    logic [63:0] dl;
  } list_req_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  id;
    logic [63:0] dl;
  } list_head_t;

endpackage

### src/sorted_deadline_timer_queue.sv
// top level of the sorted deadline timer queue
// Holds up to NTIMERS one-shot timers sorted by deadline (ties by arrival).
// Requests enter on in_push/in_full with in_data; results leave on
// out_empty/out_pop with out_data, oldest first, one or more per request,
// the final one marked by last. The APB port holds due_slack_ns at 0x0.
// A front stage forms now + delay*1000 and classifies the request into a
// two-entry command queue; the back end executes commands one at a time on a
// row of sorted cells and writes results into a two-entry result queue.
// A check converts the wait to seconds and microseconds by reciprocal
// multiplication. The back end finishes each command, wait conversion
// included, before it takes the next one from the command queue.
// Reset clears the list, both queues and sets due_slack_ns to 500000.
// When the receiver stalls, the result queue fills, the back end waits,
// then the command queue fills and in_full rises; nothing is dropped.
module sorted_deadline_timer_queue #(
  parameter int NTIMERS = sdtq_pkg::NTIMERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  sdtq_pkg::in_item_t   in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output sdtq_pkg::out_item_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import sdtq_pkg::*;

  logic [31:0] slack_r;
  logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t        cmd_in, cmd_out;
  logic        res_push, res_full;
  out_item_t   res_data;
  logic        reg_sel;

  // configuration register
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = reg_sel ? slack_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slack_r <= SLACK_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      slack_r <= cfg_pwdata;
    end
  end

  sdtq_front #(.NTIMERS(NTIMERS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .cmd_push(cmd_push), .cmd_data(cmd_in), .cmd_full(cmd_full)
  );

  sdtq_fifo #(.T(cmd_t), .DEPTH(2)) u_cmd_q (
    .clk(clk), .rst_n(rst_n), .push(cmd_push), .din(cmd_in), .full(cmd_full),
    .pop(cmd_pop), .dout(cmd_out), .empty(cmd_empty)
  );

  sdtq_back #(.NTIMERS(NTIMERS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_data(cmd_out), .cmd_empty(cmd_empty),
    .cmd_pop(cmd_pop), .slack(slack_r), .res_push(res_push),
    .res_data(res_data), .res_full(res_full)
  );

  sdtq_fifo #(.T(out_item_t), .DEPTH(2)) u_res_q (
    .clk(clk), .rst_n(rst_n), .push(res_push), .din(res_data), .full(res_full),
    .pop(out_pop), .dout(out_data), .empty(out_empty)
  );

  // checks
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result queue overflow");

  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full) else $error("command queue overflow");

  a_cmd_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty) else $error("command popped from empty queue");

endmodule

### src/sdtq_fifo.sv
// small synchronous queue used between front, back and the result port
module sdtq_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  // pointer and fill count
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

### src/sdtq_front.sv
// front end: takes requests, forms the deadline and classifies them
module sdtq_front #(
  parameter int NTIMERS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  sdtq_pkg::in_item_t in_data,
  output logic              cmd_push,
  output sdtq_pkg::cmd_t    cmd_data,
  input  logic              cmd_full
);
  import sdtq_pkg::*;

  logic     v_r;
  in_item_t item_r;
  logic [41:0] prod_r;
  logic [63:0] dl;
  logic id_ok;
  logic accept;

  assign in_full  = v_r && cmd_full;
  assign accept   = in_push && !in_full;
  assign cmd_push = v_r && !cmd_full;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= 1'b1;
    end else if (cmd_push) begin
      v_r <= 1'b0;
    end
  end

  // request and delay in nanoseconds
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      prod_r <= 42'(in_data.delay_usec) * 42'(NS_PER_USEC);
    end
  end

  // classify
  always_comb begin
    dl    = item_r.now_ns + 64'(prod_r);
    id_ok = int'(item_r.timer_id) < NTIMERS;
    cmd_data.id       = item_r.timer_id;
    cmd_data.deadline = dl;
    cmd_data.now      = item_r.now_ns;
    case (item_r.operation)
      OP_SET: begin
        if (!id_ok || item_r.delay_usec == '0 || dl == '0) begin
          cmd_data.code = CMD_REJECT;
        end else begin
          cmd_data.code = CMD_SET;
        end
      end
      OP_CANCEL: begin
        cmd_data.code = id_ok ? CMD_CANCEL : CMD_REJECT;
      end
      OP_CHECK: begin
        cmd_data.code = CMD_CHECK;
      end
      default: begin
        cmd_data.code = CMD_REJECT;
      end
    endcase
  end

endmodule

### src/sdtq_list.sv
// sorted row of timer cells: insert in order, remove by id, pop the head
module sdtq_list #(
  parameter int NTIMERS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sdtq_pkg::list_req_t   req,
  output sdtq_pkg::list_head_t  head
);
  import sdtq_pkg::*;

  logic        vld_r [NTIMERS];
  logic [3:0]  id_r  [NTIMERS];
  logic [63:0] dl_r  [NTIMERS];
  logic        vld_nxt [NTIMERS];
  logic [3:0]  id_nxt  [NTIMERS];
  logic [63:0] dl_nxt  [NTIMERS];
  logic        up_vld [NTIMERS];
  logic [3:0]  up_id  [NTIMERS];
  logic [63:0] up_dl  [NTIMERS];
  logic        le    [NTIMERS];
  logic        shift [NTIMERS];

  assign head.valid = vld_r[0];
  assign head.id    = id_r[0];
  assign head.dl    = dl_r[0];

  // neighbor below each cell, empty past the end
  always_comb begin
    for (int k = 0; k < NTIMERS - 1; k++) begin
      up_vld[k] = vld_r[k+1];
      up_id[k]  = id_r[k+1];
      up_dl[k]  = dl_r[k+1];
    end
    up_vld[NTIMERS-1] = 1'b0;
    up_id[NTIMERS-1]  = id_r[NTIMERS-1];
    up_dl[NTIMERS-1]  = dl_r[NTIMERS-1];
  end

  // per-cell compares and removal prefix
  always_comb begin
    for (int k = 0; k < NTIMERS; k++) begin
      le[k] = vld_r[k] && (dl_r[k] <= req.dl);
    end
    shift[0] = vld_r[0] && (id_r[0] == req.id);
    for (int k = 1; k < NTIMERS; k++) begin
      shift[k] = shift[k-1] || (vld_r[k] && (id_r[k] == req.id));
    end
  end

  // next cell contents
  always_comb begin
    for (int k = 0; k < NTIMERS; k++) begin
      vld_nxt[k] = vld_r[k];
      id_nxt[k]  = id_r[k];
      dl_nxt[k]  = dl_r[k];
    end
    case (req.op)
      LIST_INSERT: begin
        for (int k = 0; k < NTIMERS; k++) begin
          if (!le[k]) begin
            if (k == 0 || le[(k > 0) ? k - 1 : 0]) begin
              vld_nxt[k] = 1'b1;
              id_nxt[k]  = req.id;
              dl_nxt[k]  = req.dl;
            end else begin
              vld_nxt[k] = vld_r[(k > 0) ? k - 1 : 0];
              id_nxt[k]  = id_r[(k > 0) ? k - 1 : 0];
              dl_nxt[k]  = dl_r[(k > 0) ? k - 1 : 0];
            end
          end
        end
      end
      LIST_REMOVE: begin
        for (int k = 0; k < NTIMERS; k++) begin
          if (shift[k]) begin
            vld_nxt[k] = up_vld[k];
            id_nxt[k]  = up_id[k];
            dl_nxt[k]  = up_dl[k];
          end
        end
      end
      LIST_POP: begin
        for (int k = 0; k < NTIMERS; k++) begin
          vld_nxt[k] = up_vld[k];
          id_nxt[k]  = up_id[k];
          dl_nxt[k]  = up_dl[k];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NTIMERS; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_nxt[k];
      end
      id_r[k] <= id_nxt[k];
      dl_r[k] <= dl_nxt[k];
    end
  end

endmodule

### src/sdtq_divider.sv
// wait conversion: nanoseconds to seconds and microseconds by reciprocal multiply
module sdtq_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] wait_ns,
  output logic        done,
  output logic [34:0] sec,
  output logic [19:0] usec
);
  import sdtq_pkg::*;

  // 2^61 / 1e9 rounded down, and 2^40 / 1000 rounded up
  localparam logic [31:0] RECIP_SEC  = 32'd2305843009;
  localparam logic [30:0] RECIP_USEC = 31'd1099511628;

  logic [5:0]  stg_r;
  logic [63:0] w_r;
  logic [63:0] m_r;
  logic [34:0] q_r;
  logic [47:0] ph_r;
  logic [46:0] pl_r;
  logic [33:0] rem_r;
  logic [34:0] sec_r;
  logic [29:0] r_r;
  logic [60:0] up_r;
  logic [2:0]  k;
  logic [33:0] sub;

  assign done = stg_r[5];
  assign sec  = sec_r;
  assign usec = up_r[59:40];

  // stage valid bits, one stage per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r <= {stg_r[4:0], start};
    end
  end

  // estimate is low by at most seven seconds, pick the fix-up
  always_comb begin
    k   = '0;
    sub = '0;
    for (int j = 1; j < 8; j++) begin
      if (rem_r >= 34'(j) * 34'(NS_PER_SEC)) begin
        k   = 3'(j);
        sub = 34'(j) * 34'(NS_PER_SEC);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      w_r <= wait_ns;
    end
    if (stg_r[0]) begin
      m_r <= 64'(w_r[63:32]) * 64'(RECIP_SEC);
    end
    // back-multiply the estimate in two halves
    if (stg_r[1]) begin
      q_r  <= m_r[63:29];
      ph_r <= 48'(m_r[63:46]) * 48'(NS_PER_SEC);
      pl_r <= 47'(m_r[45:29]) * 47'(NS_PER_SEC);
    end
    // remainder is below 8e9, low 34 bits are exact
    if (stg_r[2]) begin
      rem_r <= w_r[33:0] - {ph_r[16:0], 17'b0} - pl_r[33:0];
    end
    if (stg_r[3]) begin
      sec_r <= q_r + 35'(k);
      r_r   <= 30'(rem_r - sub);
    end
    if (stg_r[4]) begin
      up_r <= 61'(r_r) * 61'(RECIP_USEC);
    end
  end

endmodule

### src/sdtq_back.sv
// back end: carries out commands on the sorted list and forms results
module sdtq_back #(
  parameter int NTIMERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdtq_pkg::cmd_t       cmd_data,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  input  logic [31:0]          slack,
  output logic                 res_push,
  output sdtq_pkg::out_item_t  res_data,
  input  logic                 res_full
);
  import sdtq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_FIRE = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_SUM  = 3'd6;

  logic [2:0]  state_r, state_nxt;
  cmd_t        cur_r;
  logic [63:0] limit_r;
  logic        any_r, any_nxt;
  list_req_t   lreq;
  list_head_t  head;
  logic        due;
  logic        div_start, div_done;
  logic [63:0] wait_ns;
  logic [34:0] sec;
  logic [19:0] usec;

  sdtq_list #(.NTIMERS(NTIMERS)) u_list (
    .clk(clk), .rst_n(rst_n), .req(lreq), .head(head)
  );

  sdtq_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .wait_ns(wait_ns),
    .done(div_done), .sec(sec), .usec(usec)
  );

  assign cmd_pop = (state_r == S_IDLE) && !cmd_empty;
  assign due     = head.valid && (head.dl <= limit_r);
  assign wait_ns = (head.valid && head.dl > cur_r.now) ? head.dl - cur_r.now : '0;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    any_nxt   = any_r;
    lreq.op   = LIST_NOP;
    lreq.id   = cur_r.id;
    lreq.dl   = cur_r.deadline;
    div_start = 1'b0;
    res_push  = 1'b0;
    res_data  = '0;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cur_r.code)
          CMD_SET: begin
            lreq.op   = LIST_REMOVE;
            state_nxt = S_INS;
          end
          CMD_CANCEL: begin
            lreq.op   = LIST_REMOVE;
            state_nxt = S_EMIT;
          end
          CMD_CHECK: begin
            any_nxt   = 1'b0;
            state_nxt = S_FIRE;
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_INS: begin
        lreq.op   = LIST_INSERT;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        res_data.kind     = (cur_r.code == CMD_REJECT) ? KIND_REJECT : KIND_DONE;
        res_data.fired_id = cur_r.id;
        res_data.last     = 1'b1;
        res_push          = !res_full;
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      S_FIRE: begin
        if (due) begin
          res_data.kind     = KIND_FIRED;
          res_data.fired_id = head.id;
          res_push          = !res_full;
          if (!res_full) begin
            lreq.op = LIST_POP;
            any_nxt = 1'b1;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        res_data.kind      = KIND_SUMMARY;
        res_data.any_fired = any_r;
        res_data.wait_sec  = sec;
        res_data.wait_usec = usec;
        res_data.last      = 1'b1;
        res_push           = !res_full;
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      any_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      any_r   <= any_nxt;
    end
  end

  // current command and fire limit
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd_data;
    end
    if (state_r == S_EXEC) begin
      limit_r <= cur_r.now + 64'(slack);
    end
  end

endmodule

### bench/tb_top.sv
// self-checking bench for the sorted deadline timer queue
module tb_top;
  import sdtq_pkg::*;

  localparam int NT = 16;
  localparam logic [63:0] NS_SEC  = 64'd1000000000;
  localparam logic [63:0] NS_USEC = 64'd1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // timer model state
  logic [63:0] dl_of [NT];
  logic [3:0] order_ids [NT];
  int unsigned n_queued;
  logic [31:0] slack_ns;

  out_item_t expected_results[$];
  int errors = 0;
  bit steady = 1'b0;
  logic [63:0] clock_ns = 64'd1000000;

  sorted_deadline_timer_queue i_dut (.*);

  always #5 clk = ~clk;

  // drop a timer from the sorted list if it is active
  function automatic void unlink_timer(logic [3:0] id);
    int i, j;
    if (dl_of[id] == 0) return;
    for (i = 0; i < n_queued; i++) begin
      if (order_ids[i] == id) begin
        for (j = i; j + 1 < n_queued; j++) order_ids[j] = order_ids[j + 1];
        n_queued--;
        break;
      end
    end
    dl_of[id] = '0;
  endfunction

  // sorted insert, equal deadlines keep arrival order
  function automatic void link_timer(logic [3:0] id, logic [63:0] dl);
    int pos, j;
    if (n_queued >= NT) return;
    pos = 0;
    while (pos < n_queued && dl_of[order_ids[pos]] <= dl) pos++;
    for (j = n_queued; j > pos; j--) order_ids[j] = order_ids[j - 1];
    order_ids[pos] = id;
    n_queued++;
    dl_of[id] = dl;
  endfunction

  function automatic out_item_t mk_result(logic [1:0] kind, logic [3:0] id);
    out_item_t r;
    r = '0;
    r.kind = kind;
    r.fired_id = id;
    return r;
  endfunction

  // expected results of one accepted request
  function automatic void predict_timer_request(in_item_t it);
    logic [63:0] dl, lim, wait_ns;
    logic [3:0] head;
    out_item_t r;
    bit any;
    int j;
    case (it.operation)
      OP_SET, OP_CANCEL: begin
        r = mk_result(KIND_DONE, it.timer_id);
        if (it.operation == OP_SET) begin
          dl = it.now_ns + {32'd0, it.delay_usec} * NS_USEC;
          if (it.delay_usec == 0 || dl == 0) r.kind = KIND_REJECT;
          else begin
            unlink_timer(it.timer_id);
            link_timer(it.timer_id, dl);
          end
        end else unlink_timer(it.timer_id);
        r.last = 1'b1;
        expected_results.push_back(r);
      end
      OP_CHECK: begin
        any = 1'b0;
        lim = it.now_ns + {32'd0, slack_ns};
        while (n_queued > 0 && dl_of[order_ids[0]] <= lim) begin
          head = order_ids[0];
          for (j = 0; j + 1 < n_queued; j++) order_ids[j] = order_ids[j + 1];
          n_queued--;
          dl_of[head] = '0;
          expected_results.push_back(mk_result(KIND_FIRED, head));
          any = 1'b1;
        end
        wait_ns = '0;
        if (n_queued > 0 && dl_of[order_ids[0]] > it.now_ns)
          wait_ns = dl_of[order_ids[0]] - it.now_ns;
        r = mk_result(KIND_SUMMARY, 4'd0);
        r.any_fired = any;
        r.wait_sec = 35'(wait_ns / NS_SEC);
        r.wait_usec = 20'((wait_ns % NS_SEC) / NS_USEC);
        r.last = 1'b1;
        expected_results.push_back(r);
      end
      default: begin
        r = mk_result(KIND_REJECT, it.timer_id);
        r.last = 1'b1;
        expected_results.push_back(r);
      end
    endcase
  endfunction

  // send one request, holding push until it is taken
  task automatic send_request(logic [1:0] op, logic [3:0] id, logic [31:0] dly,
                              logic [63:0] now);
    in_item_t it;
    it = '{operation: op, timer_id: id, delay_usec: dly, now_ns: now};
    @(negedge clk);
    while (!steady && $urandom_range(99) < 19) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_data = it;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    predict_timer_request(it);
  endtask

  // stop sending and wait until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_push = 1'b0;
    while (expected_results.size() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_slack(logic [31:0] val);
    drain_results();
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = '0;
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    slack_ns = val;
  endtask

  // result pop with random stalls
  always @(negedge clk) out_pop <= steady || ($urandom_range(99) >= 19);

  // compare each popped result with the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d", out_data.kind, out_data.fired_id);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.kind != e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_data.kind); errors++;
        end
        if (out_data.fired_id != e.fired_id) begin
          $error("fired_id exp %0d got %0d", e.fired_id, out_data.fired_id); errors++;
        end
        if (out_data.any_fired != e.any_fired) begin
          $error("any_fired exp %0d got %0d", e.any_fired, out_data.any_fired); errors++;
        end
        if (out_data.wait_sec != e.wait_sec) begin
          $error("wait_sec exp %0d got %0d", e.wait_sec, out_data.wait_sec); errors++;
        end
        if (out_data.wait_usec != e.wait_usec) begin
          $error("wait_usec exp %0d got %0d", e.wait_usec, out_data.wait_usec); errors++;
        end
        if (out_data.last != e.last) begin
          $error("last exp %0d got %0d", e.last, out_data.last); errors++;
        end
      end
    end
  end

  // rejects, inactive cancel, empty check, extreme fields
  task automatic test_rejects();
    send_request(OP_CHECK, 4'd0, 32'd0, clock_ns);
    send_request(OP_SET, 4'd0, 32'd0, clock_ns);
    send_request(OP_SET, 4'd1, 32'd5, 64'd0 - 64'd5000);
    send_request(2'd3, 4'd15, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_CANCEL, 4'd7, 32'd0, clock_ns);
    send_request(OP_SET, 4'd9, 32'hFFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
    send_request(OP_SET, 4'd10, 32'd1, 64'hFFFF_FFFF_FFFF_0000);
    send_request(OP_CHECK, 4'd0, 32'd0, 64'd0);
    send_request(OP_CANCEL, 4'd9, 32'd0, clock_ns);
    send_request(OP_CANCEL, 4'd10, 32'd0, clock_ns);
  endtask

  // full list with ties, re-set, an early check, then one check fires everything
  task automatic test_fill_and_fire();
    for (int i = 0; i < NT; i++)
      send_request(OP_SET, 4'(i), 32'((i % 4 + 1) * 10), clock_ns);
    send_request(OP_SET, 4'd3, 32'd10, clock_ns);
    send_request(OP_CHECK, 4'd0, 32'd0, clock_ns - 64'd600000);
    send_request(OP_CHECK, 4'd0, 32'd0, clock_ns);
    clock_ns += 64'd1000000;
  endtask

  // slack sum wraps past the head deadline so the wait saturates
  task automatic test_slack_wrap();
    logic [63:0] t;
    t = 64'd0 - 64'd2000000000;
    write_slack(32'hFFFF_FFFF);
    send_request(OP_SET, 4'd2, 32'd10, t);
    send_request(OP_CHECK, 4'd0, 32'd0, t + 64'd20000);
    send_request(OP_CANCEL, 4'd2, 32'd0, t);
  endtask

  // realistic traffic with some noise, across several slack settings
  task automatic test_random_traffic();
    logic [31:0] slacks [4];
    int r;
    slacks = '{32'd0, 32'hFFFF_FFFF, $urandom, SLACK_RESET};
    for (int ph = 0; ph < 4; ph++) begin
      write_slack(slacks[ph]);
      steady = (ph == 0);
      for (int k = 0; k < 75; k++) begin
        if (ph == 2 && k == 40) drain_results();
        clock_ns += 64'($urandom_range(0, 2000000));
        r = $urandom_range(99);
        if (r < 40)
          send_request(OP_SET, 4'($urandom), ($urandom_range(9) < 7) ?
                       32'($urandom_range(1, 3000)) : $urandom, clock_ns);
        else if (r < 55)
          send_request(OP_CANCEL, 4'($urandom), $urandom, clock_ns);
        else if (r < 88)
          send_request(OP_CHECK, 4'($urandom), $urandom, clock_ns);
        else
          send_request(2'($urandom), 4'($urandom), $urandom, {$urandom, $urandom});
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NT; i++) begin
      dl_of[i] = '0;
      order_ids[i] = '0;
    end
    n_queued = 0;
    slack_ns = SLACK_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_rejects();
    test_fill_and_fire();
    test_slack_wrap();
    test_random_traffic();
    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
